// ===== rtl/bptc_pkg.sv =====
// shared constants and types for the barometric compensation core
package bptc_pkg;

   // field widths
   localparam int RAW_W   = 24;
   localparam int COEF_W  = 16;
   localparam int TEMP_W  = 19;
   localparam int PRES_W  = 32;
   localparam int CSR_A_W = 3;

   // pipeline depth, output register included
   localparam int NUM_STAGES = 11;

   // calibration register indexes
   typedef enum logic [CSR_A_W-1:0] {
      CSR_SENS_BASE   = 3'd0,
      CSR_OFFSET_BASE = 3'd1,
      CSR_SENS_TEMP   = 3'd2,
      CSR_OFFSET_TEMP = 3'd3,
      CSR_REF_TEMP    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   // temperature break points in hundredths of a degree
   localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
   localparam logic signed [19:0] TEMP_COLD = -20'sd1500;

endpackage

// ===== rtl/baro_pressure_temp_compensation_core.sv =====
// second-order barometric pressure and temperature compensation pipeline
//
// One transaction carries a raw pressure and raw temperature conversion pair and
// yields one compensated temperature (0.01 C) and pressure (0.01 mbar). The datapath
// is an 11-stage pipeline: a new pair is taken every cycle while the output side does
// not stall, and each result waits in the stage 11 output register until the output side
// takes it by holding rsp_stall low. The depth is set by the 66-bit pressure
// product, which is built from a 24x20 and a 25x21 partial product, and by the
// truncating divisions that follow it. Each stage holds its transaction until the
// next stage frees up, so a stalled output fills the pipeline before req_stall rises.
// Calibration words are written through the csr_ port, which never stalls, and must
// only change while no transaction is in flight; indexes beyond the six calibration
// words are ignored.
module baro_pressure_temp_compensation_core (
   input  logic                               clock,
   input  logic                               reset,
   // calibration write port
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bptc_pkg::CSR_A_W-1:0]       csr_index,
   input  logic [bptc_pkg::COEF_W-1:0]        csr_wdata,
   // raw conversion input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bptc_pkg::RAW_W-1:0]         req_raw_pressure,
   input  logic [bptc_pkg::RAW_W-1:0]         req_raw_temperature,
   // compensated output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [bptc_pkg::TEMP_W-1:0] rsp_temperature_centi,
   output logic signed [bptc_pkg::PRES_W-1:0] rsp_pressure_centi_mbar
);
   import bptc_pkg::*;

   // calibration registers
   logic [COEF_W-1:0] sens_base_ff, offset_base_ff, sens_temp_ff;
   logic [COEF_W-1:0] offset_temp_ff, ref_temp_ff, temp_slope_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_base_ff   <= '0;
         offset_base_ff <= '0;
         sens_temp_ff   <= '0;
         offset_temp_ff <= '0;
         ref_temp_ff    <= '0;
         temp_slope_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SENS_BASE:   sens_base_ff   <= csr_wdata;
            CSR_OFFSET_BASE: offset_base_ff <= csr_wdata;
            CSR_SENS_TEMP:   sens_temp_ff   <= csr_wdata;
            CSR_OFFSET_TEMP: offset_temp_ff <= csr_wdata;
            CSR_REF_TEMP:    ref_temp_ff    <= csr_wdata;
            CSR_TEMP_SLOPE:  temp_slope_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-stage valid and hold control
   logic [NUM_STAGES-1:0] vld_ff, vld_in, stg_rdy, up_vld;

   always_comb begin
      stg_rdy[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stg_rdy[i] = !vld_ff[i] || stg_rdy[i+1];
      end
   end

   assign up_vld = {vld_ff[NUM_STAGES-2:0], req_valid};

   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         vld_in[i] = stg_rdy[i] ? up_vld[i] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !stg_rdy[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // stage 1: temperature difference
   logic [RAW_W-1:0]   s1_d1_ff;
   logic signed [24:0] s1_dt_ff, s1_dt_in;

   assign s1_dt_in = $signed({1'b0, req_raw_temperature})
                   - $signed({1'b0, ref_temp_ff, 8'b0});

   always_ff @(posedge clock) begin
      if (stg_rdy[0]) begin
         s1_d1_ff <= req_raw_pressure;
         s1_dt_ff <= s1_dt_in;
      end
   end

   // stage 2: products of dt with the calibration words and with itself
   logic [RAW_W-1:0]   s2_d1_ff;
   logic signed [41:0] s2_pt_ff, s2_poff_ff, s2_psens_ff;
   logic signed [49:0] s2_pdd_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         s2_d1_ff    <= s1_d1_ff;
         s2_pt_ff    <= 42'(s1_dt_ff * $signed({1'b0, temp_slope_ff}));
         s2_poff_ff  <= 42'(s1_dt_ff * $signed({1'b0, offset_temp_ff}));
         s2_psens_ff <= 42'(s1_dt_ff * $signed({1'b0, sens_temp_ff}));
         s2_pdd_ff   <= 50'(s1_dt_ff * s1_dt_ff);
      end
   end

   // stage 3: first-order temperature, offset and sensitivity
   logic signed [41:0] s3_tsum, s3_osum, s3_ssum;
   logic [RAW_W-1:0]   s3_d1_ff;
   logic signed [19:0] s3_temp_ff, s3_temp_in;
   logic signed [40:0] s3_off_ff, s3_off_in, s3_sens_ff, s3_sens_in;
   logic [17:0]        s3_t2_ff;

   // round toward zero by biasing negative values before the shift
   assign s3_tsum = s2_pt_ff + $signed({19'b0, {23{s2_pt_ff[41]}}});
   assign s3_osum = s2_poff_ff + $signed({35'b0, {7{s2_poff_ff[41]}}});
   assign s3_ssum = s2_psens_ff + $signed({34'b0, {8{s2_psens_ff[41]}}});

   assign s3_temp_in = $signed({s3_tsum[41], s3_tsum[41:23]}) + TEMP_REF;
   assign s3_off_in  = $signed({9'b0, offset_base_ff, 16'b0})
                     + $signed({{6{s3_osum[41]}}, s3_osum[41:7]});
   assign s3_sens_in = $signed({10'b0, sens_base_ff, 15'b0})
                     + $signed({{7{s3_ssum[41]}}, s3_ssum[41:8]});

   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         s3_d1_ff   <= s2_d1_ff;
         s3_temp_ff <= s3_temp_in;
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
         s3_t2_ff   <= s2_pdd_ff[48:31];
      end
   end

   // stage 4: cold-range detection and squared temperature deltas
   logic signed [19:0] s4_dl, s4_dv;
   logic signed [39:0] s4_dl_prod, s4_dv_prod;
   logic [RAW_W-1:0]   s4_d1_ff;
   logic signed [19:0] s4_temp_ff;
   logic signed [40:0] s4_off_ff, s4_sens_ff;
   logic [17:0]        s4_t2_ff;
   logic [35:0]        s4_dl_sq_ff, s4_dv_sq_ff;
   logic               s4_cold_ff, s4_vcold_ff;

   assign s4_dl      = s3_temp_ff - TEMP_REF;
   assign s4_dv      = s3_temp_ff - TEMP_COLD;
   assign s4_dl_prod = s4_dl * s4_dl;
   assign s4_dv_prod = s4_dv * s4_dv;

   always_ff @(posedge clock) begin
      if (stg_rdy[3]) begin
         s4_d1_ff    <= s3_d1_ff;
         s4_temp_ff  <= s3_temp_ff;
         s4_off_ff   <= s3_off_ff;
         s4_sens_ff  <= s3_sens_ff;
         s4_t2_ff    <= s3_t2_ff;
         s4_dl_sq_ff <= s4_dl_prod[35:0];
         s4_dv_sq_ff <= s4_dv_prod[35:0];
         s4_cold_ff  <= s3_temp_ff < TEMP_REF;
         s4_vcold_ff <= s3_temp_ff < TEMP_COLD;
      end
   end

   // stage 5: second-order offset and sensitivity corrections
   logic [38:0]        s5_dl5, s5_dv7;
   logic [39:0]        s5_dv11;
   logic [39:0]        s5_off2_in, s5_sens2_in, s5_off2_ff, s5_sens2_ff;
   logic [RAW_W-1:0]   s5_d1_ff;
   logic signed [19:0] s5_temp_ff;
   logic signed [40:0] s5_off_ff, s5_sens_ff;
   logic [17:0]        s5_t2_ff;
   logic               s5_cold_ff;

   assign s5_dl5  = {1'b0, s4_dl_sq_ff, 2'b0} + {3'b0, s4_dl_sq_ff};
   assign s5_dv7  = {s4_dv_sq_ff, 3'b0} - {3'b0, s4_dv_sq_ff};
   assign s5_dv11 = {1'b0, s4_dv_sq_ff, 3'b0} + {3'b0, s4_dv_sq_ff, 1'b0}
                  + {4'b0, s4_dv_sq_ff};

   always_comb begin
      s5_off2_in  = {2'b0, s5_dl5[38:1]};
      s5_sens2_in = {3'b0, s5_dl5[38:2]};
      if (s4_vcold_ff) begin
         s5_off2_in  = s5_off2_in + {1'b0, s5_dv7};
         s5_sens2_in = s5_sens2_in + {1'b0, s5_dv11[39:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[4]) begin
         s5_d1_ff    <= s4_d1_ff;
         s5_temp_ff  <= s4_temp_ff;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_t2_ff    <= s4_t2_ff;
         s5_cold_ff  <= s4_cold_ff;
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
      end
   end

   // stage 6: apply corrections in the cold range
   logic [RAW_W-1:0]   s6_d1_ff;
   logic signed [19:0] s6_temp_ff, s6_temp_in;
   logic signed [40:0] s6_off_ff, s6_off_in, s6_sens_ff, s6_sens_in;

   always_comb begin
      s6_temp_in = s5_temp_ff;
      s6_off_in  = s5_off_ff;
      s6_sens_in = s5_sens_ff;
      if (s5_cold_ff) begin
         s6_temp_in = s5_temp_ff - $signed({2'b0, s5_t2_ff});
         s6_off_in  = s5_off_ff - $signed({1'b0, s5_off2_ff});
         s6_sens_in = s5_sens_ff - $signed({1'b0, s5_sens2_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[5]) begin
         s6_d1_ff   <= s5_d1_ff;
         s6_temp_ff <= s6_temp_in;
         s6_off_ff  <= s6_off_in;
         s6_sens_ff <= s6_sens_in;
      end
   end

   // stage 7: raw pressure times sensitivity, as two partial products
   logic signed [19:0] s7_temp_ff;
   logic signed [40:0] s7_off_ff;
   logic [43:0]        s7_pp_lo_ff;
   logic signed [45:0] s7_pp_hi_ff;
   logic signed [20:0] s7_sens_hi;

   assign s7_sens_hi = s6_sens_ff[40:20];

   always_ff @(posedge clock) begin
      if (stg_rdy[6]) begin
         s7_temp_ff  <= s6_temp_ff;
         s7_off_ff   <= s6_off_ff;
         s7_pp_lo_ff <= s6_d1_ff * s6_sens_ff[19:0];
         s7_pp_hi_ff <= 46'($signed({1'b0, s6_d1_ff}) * s7_sens_hi);
      end
   end

   // stage 8: combine partial products
   logic signed [19:0] s8_temp_ff;
   logic signed [40:0] s8_off_ff;
   logic signed [65:0] s8_prod_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[7]) begin
         s8_temp_ff <= s7_temp_ff;
         s8_off_ff  <= s7_off_ff;
         s8_prod_ff <= $signed({s7_pp_hi_ff, 20'b0}) + $signed({22'b0, s7_pp_lo_ff});
      end
   end

   // stage 9: product divided by 2^21, toward zero
   logic signed [65:0] s9_sum;
   logic signed [19:0] s9_temp_ff;
   logic signed [40:0] s9_off_ff;
   logic signed [44:0] s9_quo_ff;

   assign s9_sum = s8_prod_ff + $signed({45'b0, {21{s8_prod_ff[65]}}});

   always_ff @(posedge clock) begin
      if (stg_rdy[8]) begin
         s9_temp_ff <= s8_temp_ff;
         s9_off_ff  <= s8_off_ff;
         s9_quo_ff  <= s9_sum[65:21];
      end
   end

   // stage 10: remove offset
   logic signed [19:0] s10_temp_ff;
   logic signed [45:0] s10_diff_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[9]) begin
         s10_temp_ff <= s9_temp_ff;
         s10_diff_ff <= $signed({s9_quo_ff[44], s9_quo_ff})
                      - $signed({{5{s9_off_ff[40]}}, s9_off_ff});
      end
   end

   // stage 11: divide by 2^15 toward zero into the output register
   // the quotient always fits the signed 32-bit range, so no clamp is left to apply
   logic signed [45:0]        s11_sum;
   logic signed [TEMP_W-1:0]  s11_temp_ff;
   logic signed [PRES_W-1:0]  s11_pres_ff;

   assign s11_sum = s10_diff_ff + $signed({31'b0, {15{s10_diff_ff[45]}}});

   always_ff @(posedge clock) begin
      if (stg_rdy[10]) begin
         s11_temp_ff <= s10_temp_ff[TEMP_W-1:0];
         s11_pres_ff <= $signed({s11_sum[45], s11_sum[45:15]});
      end
   end

   assign rsp_temperature_centi   = s11_temp_ff;
   assign rsp_pressure_centi_mbar = s11_pres_ff;

endmodule

// ===== dv/baro_pressure_temp_compensation_core_tb.sv =====
// self-checking testbench for the barometric pressure and temperature compensation core
module testbench;
   import bptc_pkg::*;

   localparam int NUM_COEFFS  = 6;
   localparam int RAW_MAX     = (1 << RAW_W) - 1;
   localparam int COEF_MAX    = (1 << COEF_W) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 16;
   localparam int PHASE_ITEMS = 106;
   localparam int MAX_REPORTS = 40;

   // scale factors of the compensation math
   localparam longint DT_REF_MUL    = 64'sd256;
   localparam longint TEMP_DIV      = 64'sd8388608;
   localparam longint OFF_BASE_MUL  = 64'sd65536;
   localparam longint OFF_DIV       = 64'sd128;
   localparam longint SENS_BASE_MUL = 64'sd32768;
   localparam longint SENS_DIV      = 64'sd256;
   localparam longint T2_DIV        = 64'sd2147483648;
   localparam longint PROD_DIV      = 64'sd2097152;
   localparam longint PRES_DIV      = 64'sd32768;
   localparam longint PRES_MAX      = 64'sd2147483647;
   localparam longint PRES_MIN      = -64'sd2147483648;

   // calibration words of a typical sensor
   localparam logic [COEF_W-1:0] TYPICAL_COEFFS [NUM_COEFFS] =
      '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

   typedef enum logic [1:0] {
      REGIME_WARM,
      REGIME_COLD,
      REGIME_VERY_COLD
   } regime_type;

   typedef struct {
      logic signed [TEMP_W-1:0] temperature;
      logic signed [PRES_W-1:0] pressure;
      regime_type               regime;
   } reading_type;

   logic                      clock               = 1'b0;
   logic                      reset               = 1'b1;
   logic                      csr_valid           = 1'b0;
   logic                      csr_ready;
   logic [CSR_A_W-1:0]        csr_index           = '0;
   logic [COEF_W-1:0]         csr_wdata           = '0;
   logic                      req_valid           = 1'b0;
   logic                      req_stall;
   logic [RAW_W-1:0]          req_raw_pressure    = '0;
   logic [RAW_W-1:0]          req_raw_temperature = '0;
   logic                      rsp_valid;
   logic                      rsp_stall           = 1'b0;
   logic signed [TEMP_W-1:0]  rsp_temperature_centi;
   logic signed [PRES_W-1:0]  rsp_pressure_centi_mbar;

   logic [COEF_W-1:0] coeff_shadow [NUM_COEFFS] = '{default: '0};
   reading_type       pending_readings [$];
   int                req_idle_pct     = 0;
   int                rsp_idle_pct     = 0;
   int                errors           = 0;
   int                pairs_sent       = 0;
   int                readings_checked = 0;
   int                cold_pairs       = 0;
   int                very_cold_pairs  = 0;
   int                settings_loaded  = 0;
   int                cycle_count      = 0;

   baro_pressure_temp_compensation_core u_dut (.*);

   always #6 clock = ~clock;

   // compensated reading for one raw pair under the current calibration
   function automatic reading_type compensate_reading(input logic [RAW_W-1:0] raw_p,
                                                      input logic [RAW_W-1:0] raw_t);
      longint      d1, d2, c1, c2, c3, c4, c5, c6;
      longint      dt, temp, off, sens, t2, dl, off2, sens2, dv, pres;
      reading_type r;
      d1 = raw_p;
      d2 = raw_t;
      c1 = coeff_shadow[CSR_SENS_BASE];
      c2 = coeff_shadow[CSR_OFFSET_BASE];
      c3 = coeff_shadow[CSR_SENS_TEMP];
      c4 = coeff_shadow[CSR_OFFSET_TEMP];
      c5 = coeff_shadow[CSR_REF_TEMP];
      c6 = coeff_shadow[CSR_TEMP_SLOPE];
      dt   = d2 - c5 * DT_REF_MUL;
      temp = TEMP_REF + dt * c6 / TEMP_DIV;
      off  = c2 * OFF_BASE_MUL + c4 * dt / OFF_DIV;
      sens = c1 * SENS_BASE_MUL + c3 * dt / SENS_DIV;
      r.regime = REGIME_WARM;
      // second-order correction below twenty degrees
      if (temp < TEMP_REF) begin
         r.regime = REGIME_COLD;
         t2    = dt * dt / T2_DIV;
         dl    = temp - TEMP_REF;
         off2  = 5 * dl * dl / 2;
         sens2 = 5 * dl * dl / 4;
         // extra term below minus fifteen degrees
         if (temp < TEMP_COLD) begin
            r.regime = REGIME_VERY_COLD;
            dv    = temp - TEMP_COLD;
            off2  += 7 * dv * dv;
            sens2 += 11 * dv * dv / 2;
         end
         temp -= t2;
         off  -= off2;
         sens -= sens2;
      end
      pres = (d1 * sens / PROD_DIV - off) / PRES_DIV;
      if (pres > PRES_MAX) begin
         pres = PRES_MAX;
      end else if (pres < PRES_MIN) begin
         pres = PRES_MIN;
      end
      r.temperature = temp[TEMP_W-1:0];
      r.pressure    = pres[PRES_W-1:0];
      return r;
   endfunction

   // calibration word: full random, an extreme, or near a typical value
   function automatic logic [COEF_W-1:0] pick_coeff(input int index);
      case ($urandom_range(3, 0))
         0: begin
            return COEF_W'($urandom_range(COEF_MAX, 0));
         end
         1: begin
            return $urandom_range(1, 0) ? COEF_W'(COEF_MAX) : '0;
         end
         default: begin
            return TYPICAL_COEFFS[index] ^ COEF_W'($urandom_range(4095, 0));
         end
      endcase
   endfunction

   // raw temperature aimed at the break points now and then
   function automatic logic [RAW_W-1:0] pick_raw_temperature();
      longint      c6, dt_aim, spread, d2;
      int unsigned sel;
      sel = $urandom_range(9, 0);
      c6  = coeff_shadow[CSR_TEMP_SLOPE];
      if (sel == 0) begin
         return $urandom_range(1, 0) ? RAW_W'(RAW_MAX) : '0;
      end
      if (sel > 4 || c6 == 0) begin
         return RAW_W'($urandom_range(RAW_MAX, 0));
      end
      dt_aim = (sel <= 2) ? 64'sd0 : (longint'(TEMP_COLD) - TEMP_REF) * TEMP_DIV / c6;
      spread = 2 * TEMP_DIV / c6 + 2;
      d2 = longint'(coeff_shadow[CSR_REF_TEMP]) * DT_REF_MUL + dt_aim
           + longint'($urandom_range(2 * spread, 0)) - spread;
      if (d2 < 0) begin
         d2 = 0;
      end else if (d2 > RAW_MAX) begin
         d2 = RAW_MAX;
      end
      return d2[RAW_W-1:0];
   endfunction

   // one register write, valid left high for a following write
   task automatic write_reg(input logic [CSR_A_W-1:0] index, input logic [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index < NUM_COEFFS) begin
         coeff_shadow[index] = value;
      end
   endtask

   // load all six calibration words
   task automatic program_coeffs(input logic [COEF_W-1:0] words [NUM_COEFFS]);
      for (int i = 0; i < NUM_COEFFS; i++) begin
         write_reg(CSR_A_W'(i), words[i]);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // send one conversion pair and queue its expected reading
   task automatic send_pair(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
      reading_type r;
      if (req_idle_pct != 0 && $urandom_range(99, 0) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_raw_pressure    <= raw_p;
      req_raw_temperature <= raw_t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = compensate_reading(raw_p, raw_t);
      pending_readings.push_back(r);
      pairs_sent++;
      if (r.regime != REGIME_WARM) cold_pairs++;
      if (r.regime == REGIME_VERY_COLD) very_cold_pairs++;
   endtask

   // stop sending until every queued reading has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   // output stall bursts
   always begin
      @(posedge clock);
      if (rsp_idle_pct != 0 && $urandom_range(99, 0) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(17, 1)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted reading with the oldest expectation
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            if (errors < MAX_REPORTS) begin
               $display("%0t: unexpected reading, temperature %0d pressure %0d", $time,
                        rsp_temperature_centi, rsp_pressure_centi_mbar);
            end
            errors++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (rsp_temperature_centi !== want.temperature) begin
               if (errors < MAX_REPORTS) begin
                  $display("%0t: temperature mismatch, expected %0d actual %0d", $time,
                           want.temperature, rsp_temperature_centi);
               end
               errors++;
            end
            if (rsp_pressure_centi_mbar !== want.pressure) begin
               if (errors < MAX_REPORTS) begin
                  $display("%0t: pressure mismatch, expected %0d actual %0d", $time,
                           want.pressure, rsp_pressure_centi_mbar);
               end
               errors++;
            end
         end
      end
   end

   // calibration at reset is all zero
   task automatic test_reset_coeffs();
      send_pair('0, '0);
      send_pair(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
      wait_for_drain();
   endtask

   // typical sensor, warm, cold and raw extremes
   task automatic test_nominal();
      program_coeffs(TYPICAL_COEFFS);
      send_pair(24'd9085466, 24'd8569150);
      send_pair('0, '0);
      send_pair(RAW_W'(RAW_MAX), 24'd8569150);
      send_pair(24'd9085466, '0);
      send_pair(24'd9085466, RAW_W'(RAW_MAX));
      wait_for_drain();
   endtask

   // exact edges of the cold and very cold regions, with truncation of negative dT
   task automatic test_temp_thresholds();
      logic [COEF_W-1:0] words [NUM_COEFFS];
      int                dt_edges [7];
      words    = TYPICAL_COEFFS;
      words[CSR_REF_TEMP]   = 16'd32768;
      words[CSR_TEMP_SLOPE] = 16'd32768;
      dt_edges = '{0, -255, -256, 255, -896000, -896255, -896256};
      program_coeffs(words);
      foreach (dt_edges[i]) begin
         send_pair(24'd9085466, RAW_W'(8388608 + dt_edges[i]));
      end
      wait_for_drain();
   endtask

   // every calibration word at its maximum: hottest and coldest readings
   task automatic test_coeff_extremes();
      logic [COEF_W-1:0] words [NUM_COEFFS];
      words = '{default: COEF_W'(COEF_MAX)};
      program_coeffs(words);
      send_pair('0, '0);
      send_pair(RAW_W'(RAW_MAX), '0);
      send_pair('0, RAW_W'(RAW_MAX));
      send_pair(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
      wait_for_drain();
   endtask

   // writes past the last calibration word must leave it untouched
   task automatic test_unused_index();
      for (int i = NUM_COEFFS; i < (1 << CSR_A_W); i++) begin
         write_reg(CSR_A_W'(i), '0);
      end
      csr_valid <= 1'b0;
      send_pair(24'd9085466, 24'd8569150);
      send_pair(RAW_W'(RAW_MAX), '0);
      wait_for_drain();
   endtask

   // random calibrations and conversion pairs under varying back pressure
   task automatic test_random_phases();
      logic [COEF_W-1:0] words [NUM_COEFFS];
      logic [RAW_W-1:0]  raw_p;
      int                pause_at;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int i = 0; i < NUM_COEFFS; i++) begin
            if (phase == 0) begin
               words[i] = COEF_W'(COEF_MAX);
            end else if (phase == 1) begin
               words[i] = '0;
            end else begin
               words[i] = pick_coeff(i);
            end
         end
         program_coeffs(words);
         // quiet phases now and then, and always at the end
         if (phase >= NUM_PHASES - 3 || phase % 4 == 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = $urandom_range(40, 5);
            rsp_idle_pct = $urandom_range(20, 2);
         end
         pause_at = $urandom_range(PHASE_ITEMS - 1, 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == pause_at) wait_for_drain();
            if ($urandom_range(9, 0) == 0) begin
               raw_p = $urandom_range(1, 0) ? RAW_W'(RAW_MAX) : '0;
            end else begin
               raw_p = RAW_W'($urandom_range(RAW_MAX, 0));
            end
            send_pair(raw_p, pick_raw_temperature());
         end
         wait_for_drain();
      end
   endtask

   // run watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
               pending_readings.size());
      $display("baro_pressure_temp_compensation_core test failed");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_coeffs();
      test_nominal();
      test_temp_thresholds();
      test_coeff_extremes();
      test_unused_index();
      test_random_phases();
      wait_for_drain();
      repeat (NUM_STAGES + 8) @(posedge clock);
      if (pending_readings.size() != 0) begin
         $display("%0t: %0d expected readings never arrived", $time, pending_readings.size());
         errors++;
      end
      $display("covered %0d conversion pairs (%0d cold, %0d very cold), %0d readings checked",
               pairs_sent, cold_pairs, very_cold_pairs, readings_checked);
      $display("over %0d calibration settings, %0d mismatches", settings_loaded, errors);
      if (errors == 0) begin
         $display("baro_pressure_temp_compensation_core test passed");
      end else begin
         $display("baro_pressure_temp_compensation_core test failed");
      end
      $finish;
   end

endmodule
